>>> rtl/mpi_pkg.sv
// ----------------------------------------------------------------------------
// mpi_pkg
// Shared types, widths and fixed-point helpers for the escape-time pixel
// iterator (signed Q4.28 arithmetic with saturation).
// ----------------------------------------------------------------------------
package mpi_pkg;

  localparam int PIXEL_BITS  = 11;
  localparam int FRAC_BITS   = 28;
  localparam int COUNT_BITS  = 16;
  localparam int WORD_BITS   = 32;
  localparam int UWORD_BITS  = WORD_BITS - 1;
  localparam int WIDE_BITS   = 2 * WORD_BITS;
  localparam int PROD_BITS   = PIXEL_BITS + UWORD_BITS;
  localparam int COLOR_BITS  = 8;
  localparam int QUEUE_DEPTH = 2;
  localparam int CFG_INDEX_BITS = 3;

  // Register indexes of the configuration port
  localparam logic [CFG_INDEX_BITS-1:0] REG_ORIGIN_RE = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ORIGIN_IM = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_STEP_RE   = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_STEP_IM   = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ITER_LIM  = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RADIUS_SQ = 3'd5;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic [UWORD_BITS-1:0]       uword_t;
  typedef logic signed [WIDE_BITS-1:0] wide_t;
  typedef logic [PIXEL_BITS-1:0]       pix_t;
  typedef logic [COUNT_BITS-1:0]       count_t;
  typedef logic [COLOR_BITS-1:0]       color_t;

  typedef struct packed {
    word_t  origin_re;
    word_t  origin_im;
    uword_t step_re;
    uword_t step_im;
    count_t iteration_limit;
    uword_t radius_squared;
  } cfg_t;

  typedef struct packed {
    pix_t pixel_col;
    pix_t pixel_row;
  } pixel_in_t;

  typedef struct packed {
    pix_t   out_col;
    pix_t   out_row;
    count_t iteration_count;
    logic   inside_res;
    color_t red;
    color_t green;
    color_t blue;
  } pixel_out_t;

  // Mapped point waiting for the iteration engine
  typedef struct packed {
    pix_t  col;
    pix_t  row;
    word_t c_re;
    word_t c_im;
  } coord_t;

  // Finished pixel from the iteration engine
  typedef struct packed {
    pix_t   col;
    pix_t   row;
    count_t count;
    logic   in_set;
  } iter_res_t;

  // Clamp a wide signed value to the signed word range
  function automatic word_t sat_word(input wide_t v);
    logic [WIDE_BITS-WORD_BITS:0] top;
    top = v[WIDE_BITS-1:WORD_BITS-1];
    if (&top || ~|top) begin
      return v[WORD_BITS-1:0];
    end
    return v[WIDE_BITS-1] ? {1'b1, {(WORD_BITS-1){1'b0}}} : {1'b0, {(WORD_BITS-1){1'b1}}};
  endfunction

  // Exact product, floor shift, saturate
  function automatic word_t qmul(input word_t a, input word_t b, input int unsigned sh);
    wide_t p;
    p = wide_t'(a) * wide_t'(b);
    return sat_word(p >>> sh);
  endfunction

  localparam int COUNT_BYTES = (COUNT_BITS + COLOR_BITS - 1) / COLOR_BITS;
  localparam int MOD_SUM_BITS = COLOR_BITS + $clog2(COUNT_BYTES + 1) + 1;

  // n mod 255: 256 is 1 mod 255, so add the bytes and fold
  function automatic color_t mod255(input count_t n);
    logic [COUNT_BYTES*COLOR_BITS-1:0] ext;
    logic [MOD_SUM_BITS-1:0]           s;
    ext = (COUNT_BYTES*COLOR_BITS)'(n);
    s = '0;
    for (int i = 0; i < COUNT_BYTES; i++) begin
      s = s + MOD_SUM_BITS'(ext[i*COLOR_BITS +: COLOR_BITS]);
    end
    for (int i = 0; i < COUNT_BYTES; i++) begin
      if (s >= MOD_SUM_BITS'(255)) begin
        s = s - MOD_SUM_BITS'(255);
      end
    end
    return s[COLOR_BITS-1:0];
  endfunction

  // Times 2^k mod 255 of a residue is a byte rotate
  function automatic color_t rotl(input color_t v, input int unsigned k);
    logic [2*COLOR_BITS-1:0] d;
    d = {v, v} << k;
    return d[2*COLOR_BITS-1:COLOR_BITS];
  endfunction

endpackage

>>> rtl/mpi_front.sv
// ----------------------------------------------------------------------------
// mpi_front
// Accept pixel coordinates and map them to the complex point c:
// origin plus index times step, saturated to the word range.
// ----------------------------------------------------------------------------
module mpi_front (
  input  logic              clk,
  input  logic              rst_n,
  input  mpi_pkg::cfg_t     cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  mpi_pkg::pixel_in_t in_data,
  output logic              c_valid,
  input  logic              c_ready,
  output mpi_pkg::coord_t   c_data
);
  import mpi_pkg::*;

  logic                 valid_r;
  pix_t                 col_r, row_r;
  logic [PROD_BITS-1:0] prod_re_r, prod_im_r;
  logic                 take;

  assign in_ready = !valid_r || c_ready;
  assign take     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // Multiply on transfer, add in the next cycle
  always_ff @(posedge clk) begin
    if (take) begin
      col_r     <= in_data.pixel_col;
      row_r     <= in_data.pixel_row;
      prod_re_r <= PROD_BITS'(in_data.pixel_col) * PROD_BITS'(cfg.step_re);
      prod_im_r <= PROD_BITS'(in_data.pixel_row) * PROD_BITS'(cfg.step_im);
    end
  end

  assign c_valid     = valid_r;
  assign c_data.col  = col_r;
  assign c_data.row  = row_r;
  assign c_data.c_re = sat_word(wide_t'(cfg.origin_re) + $signed(WIDE_BITS'(prod_re_r)));
  assign c_data.c_im = sat_word(wide_t'(cfg.origin_im) + $signed(WIDE_BITS'(prod_im_r)));

endmodule

>>> rtl/mpi_queue.sv
// ----------------------------------------------------------------------------
// mpi_queue
// Short FIFO of mapped points between the front end and the iteration engine.
// ----------------------------------------------------------------------------
module mpi_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  mpi_pkg::coord_t push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output mpi_pkg::coord_t pop_data
);
  import mpi_pkg::*;

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  coord_t              mem [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_BITS-1:0] count_r;
  logic                push, pop;

  function automatic logic [PTR_BITS-1:0] ptr_inc(input logic [PTR_BITS-1:0] p);
    return (p == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign push_ready = count_r != CNT_BITS'(QUEUE_DEPTH);
  assign pop_valid  = count_r != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> rtl/mpi_core.sv
// ----------------------------------------------------------------------------
// mpi_core
// Iteration engine: z = z*z + c from z = c, each iteration a product state
// (square and cross products), then an update and escape test state.
// ----------------------------------------------------------------------------
module mpi_core (
  input  logic               clk,
  input  logic               rst_n,
  input  mpi_pkg::cfg_t      cfg,
  input  logic               q_valid,
  output logic               q_ready,
  input  mpi_pkg::coord_t    q_data,
  output logic               res_valid,
  input  logic               res_ready,
  output mpi_pkg::iter_res_t res
);
  import mpi_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_UPD  = 4'b0100,
    ST_DONE = 4'b1000
  } core_state_t;

  core_state_t state_r, state_nxt;
  word_t       x_r, y_r, cre_r, cim_r;
  word_t       xx_r, yy_r, xy2_r;
  pix_t        col_r, row_r;
  count_t      count_r;

  word_t  mag, x_upd, y_upd;
  logic   escaped, limit_hit, finish;

  // Magnitude of the previous update's result is xx + yy of this round
  assign mag       = sat_word(wide_t'(xx_r) + wide_t'(yy_r));
  assign escaped   = !(mag < word_t'({1'b0, cfg.radius_squared}));
  assign limit_hit = count_r >= cfg.iteration_limit;
  assign finish    = (count_r != '0) && (escaped || limit_hit);
  assign x_upd     = sat_word(wide_t'(sat_word(wide_t'(xx_r) - wide_t'(yy_r))) + wide_t'(cre_r));
  assign y_upd     = sat_word(wide_t'(xy2_r) + wide_t'(cim_r));

  assign q_ready   = state_r == ST_IDLE;
  assign res_valid = state_r == ST_DONE;
  assign res.col    = col_r;
  assign res.row    = row_r;
  assign res.count  = count_r;
  assign res.in_set = limit_hit;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (q_valid) state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_UPD;
      ST_UPD:  state_nxt = finish ? ST_DONE : ST_MUL;
      ST_DONE: if (res_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && q_valid) begin
      x_r     <= q_data.c_re;
      y_r     <= q_data.c_im;
      cre_r   <= q_data.c_re;
      cim_r   <= q_data.c_im;
      col_r   <= q_data.col;
      row_r   <= q_data.row;
      count_r <= '0;
    end
    if (state_r == ST_MUL) begin
      xx_r  <= qmul(x_r, x_r, FRAC_BITS);
      yy_r  <= qmul(y_r, y_r, FRAC_BITS);
      xy2_r <= qmul(x_r, y_r, FRAC_BITS - 1);
    end
    if (state_r == ST_UPD && !finish) begin
      x_r     <= x_upd;
      y_r     <= y_upd;
      count_r <= count_r + 1'b1;
    end
  end

  // Count stays within the limit, but for the forced first iteration
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE && count_r > cfg.iteration_limit) |-> count_r == COUNT_BITS'(1))
    else $error("iteration count ran past the limit");

  // The first update always runs
  a_first_iter: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD && count_r == '0) |=> (state_r == ST_MUL && count_r == COUNT_BITS'(1)))
    else $error("first iteration skipped");

  // A finished pixel holds until the output stage takes it
  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res_ready) |=> (res_valid && $stable(res)))
    else $error("finished pixel dropped or changed while stalled");

endmodule

>>> rtl/mandelbrot_pixel_iterator_unit.sv
// ----------------------------------------------------------------------------
// mandelbrot_pixel_iterator_unit
// Escape-time pixel iterator in signed Q4.28: maps a pixel to c, iterates
// z = z*z + c and returns the iteration count, inside flag and colors.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+-------------------------------
//  in_      | input     | in_valid / in_ready   | pixel_in_t (column, row)
//  out_     | output    | out_valid / out_ready | pixel_out_t (echo, count, RGB)
//  cfg_     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// In the iteration engine, each iteration of a pixel runs one state of three
// 32x32 products and one state of update and escape test, plus one final
// product/test round and the hand-off of the result.
// The front end maps the next pixel and queues up to two of them while the
// engine works; a finished pixel waits in the output register.
// Reset (synchronous, rst_n low) empties all stages and loads the default
// view registers. cfg_ready is always high.
// ----------------------------------------------------------------------------
module mandelbrot_pixel_iterator_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  mpi_pkg::pixel_in_t                    in_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output mpi_pkg::pixel_out_t                   out_data,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [mpi_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [mpi_pkg::WORD_BITS-1:0]         cfg_data
);
  import mpi_pkg::*;

  cfg_t       cfg_r;
  logic       c_valid, c_ready;
  coord_t     c_data;
  logic       q_valid, q_ready;
  coord_t     q_data;
  logic       res_valid, res_ready;
  iter_res_t  res;
  logic       out_valid_r;
  pixel_out_t out_data_r;
  color_t     green_mod;

  // Configuration registers: write on every transfer, ignore unknown indexes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_re       <= -word_t'(32'sd536870912);
      cfg_r.origin_im       <= -word_t'(32'sd268435456);
      cfg_r.step_re         <= UWORD_BITS'(786432);
      cfg_r.step_im         <= UWORD_BITS'(524288);
      cfg_r.iteration_limit <= COUNT_BITS'(256);
      cfg_r.radius_squared  <= UWORD_BITS'(1073741824);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ORIGIN_RE: cfg_r.origin_re       <= cfg_data;
        REG_ORIGIN_IM: cfg_r.origin_im       <= cfg_data;
        REG_STEP_RE:   cfg_r.step_re         <= cfg_data[UWORD_BITS-1:0];
        REG_STEP_IM:   cfg_r.step_im         <= cfg_data[UWORD_BITS-1:0];
        REG_ITER_LIM:  cfg_r.iteration_limit <= cfg_data[COUNT_BITS-1:0];
        REG_RADIUS_SQ: cfg_r.radius_squared  <= cfg_data[UWORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Front end: map pixel to c
  mpi_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .c_valid  (c_valid),
    .c_ready  (c_ready),
    .c_data   (c_data)
  );

  // Decouple mapping from iteration
  mpi_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (c_valid),
    .push_ready (c_ready),
    .push_data  (c_data),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  // Back end: escape-time iteration
  mpi_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_data    (q_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output register: take a finished pixel when empty or draining
  assign res_ready = !out_valid_r || out_ready;
  assign green_mod = mod255(res.count);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  // Colors: red, green, blue are 8n, n, 4n mod 255 as rotations of one residue; black when inside
  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r.out_col         <= res.col;
      out_data_r.out_row         <= res.row;
      out_data_r.iteration_count <= res.count;
      out_data_r.inside_res      <= res.in_set;
      out_data_r.red             <= res.in_set ? '0 : rotl(green_mod, 3);
      out_data_r.green           <= res.in_set ? '0 : green_mod;
      out_data_r.blue            <= res.in_set ? '0 : rotl(green_mod, 2);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> tb/mandelbrot_pixel_iterator_unit_tb.sv
// ----------------------------------------------------------------------------
// mandelbrot_pixel_iterator_unit_tb
// Self-checking bench for the escape-time pixel iterator. A queue-fed driver
// pushes pixel coordinates and a monitor compares every returned pixel with a
// fixed-point escape-time predictor run on the same view settings. The run
// walks through several view settings, register extremes, and phases of
// source idling and sink back-pressure.
// ----------------------------------------------------------------------------
module mandelbrot_pixel_iterator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mpi_pkg::*;

  localparam int     WATCHDOG_LIMIT = 600000;  // idle cycles before giving up
  localparam int     DRAIN_CYCLES   = 64;
  localparam int     MAX_REPORTS    = 10;
  localparam int     RANDOM_VIEWS   = 7;
  localparam int     VIEW_PIXELS    = 100;
  localparam longint WORD_MAX       = 64'sd2147483647;
  localparam longint WORD_MIN       = -64'sd2147483648;

  // Q4.28 constants used for the view setups
  localparam word_t  Q_MINUS_TWO    = -32'sd536870912;
  localparam word_t  Q_MINUS_ONE    = -32'sd268435456;
  localparam word_t  Q_THREE        = 32'sd805306368;
  localparam uword_t Q_FOUR         = 31'd1073741824;
  localparam uword_t DEF_STEP_RE    = 31'd786432;
  localparam uword_t DEF_STEP_IM    = 31'd524288;
  localparam count_t DEF_LIMIT      = 16'd256;
  localparam word_t  SWORD_MAX      = 32'sh7fff_ffff;
  localparam word_t  SWORD_MIN      = 32'sh8000_0000;
  localparam uword_t UWORD_MAX      = 31'h7fff_ffff;
  localparam count_t LIMIT_MAX      = 16'hffff;

  logic                      clk       = 1'b0;
  logic                      rst_n     = 1'b0;
  logic                      in_valid  = 1'b0;
  logic                      in_ready;
  pixel_in_t                 in_data   = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  pixel_out_t                out_data;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = REG_ORIGIN_RE;
  logic [WORD_BITS-1:0]      cfg_data  = '0;

  // Predictor copy of the view registers, starting at their reset values
  longint      view_origin_re = -64'sd536870912;
  longint      view_origin_im = -64'sd268435456;
  longint      view_step_re   = 64'sd786432;
  longint      view_step_im   = 64'sd524288;
  int unsigned view_limit     = 256;
  longint      view_radius_sq = 64'sd1073741824;

  pixel_in_t   pixel_backlog[$];    // coordinates not yet offered to the block
  pixel_out_t  pixel_expected[$];   // predicted pixels, oldest first
  int          src_idle_pct = 0;
  int          snk_idle_pct = 0;
  int          mismatches   = 0;
  int          quiet_cycles = 0;
  pixel_out_t  want_pixel;

  mandelbrot_pixel_iterator_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // --------------------------------------------------------------------------
  // Escape-time predictor
  // --------------------------------------------------------------------------

  // Clamp to the signed 32-bit range
  function automatic longint clamp_word(input longint v);
    if (v > WORD_MAX) begin
      return WORD_MAX;
    end
    if (v < WORD_MIN) begin
      return WORD_MIN;
    end
    return v;
  endfunction

  // Exact product, arithmetic shift (floor), then clamp
  function automatic longint fx_mul(input longint a, input longint b, input int sh);
    return clamp_word((a * b) >>> sh);
  endfunction

  function automatic pixel_out_t escape_pixel(input pixel_in_t px);
    longint      c_re, c_im, zr, zi, sq_re, sq_im, sq_xy, mag;
    int unsigned n;
    bit          gone;
    bit          in_set;
    pixel_out_t  r;
    c_re = clamp_word(view_origin_re + longint'(px.pixel_col) * view_step_re);
    c_im = clamp_word(view_origin_im + longint'(px.pixel_row) * view_step_im);
    zr   = c_re;
    zi   = c_im;
    n    = 0;
    // The first update always runs, even with a limit of zero
    do begin
      sq_re = fx_mul(zr, zr, FRAC_BITS);
      sq_im = fx_mul(zi, zi, FRAC_BITS);
      sq_xy = fx_mul(zr, zi, FRAC_BITS - 1);  // 2*x*y in one shift
      zr    = clamp_word(clamp_word(sq_re - sq_im) + c_re);
      zi    = clamp_word(sq_xy + c_im);
      mag   = clamp_word(fx_mul(zr, zr, FRAC_BITS) + fx_mul(zi, zi, FRAC_BITS));
      gone  = !(mag < view_radius_sq);
      n++;
    end while (!gone && n < view_limit);
    // Escaping on the very last allowed iteration still reports inside
    in_set            = (n >= view_limit);
    r.out_col         = px.pixel_col;
    r.out_row         = px.pixel_row;
    r.iteration_count = count_t'(n);
    r.inside_res      = in_set;
    r.red             = in_set ? '0 : color_t'((8 * n) % 255);
    r.green           = in_set ? '0 : color_t'(n % 255);
    r.blue            = in_set ? '0 : color_t'((4 * n) % 255);
    return r;
  endfunction

  // Mirror a register write into the predictor's view
  function automatic void apply_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                                    input logic [WORD_BITS-1:0] value);
    case (idx)
      REG_ORIGIN_RE: view_origin_re = longint'($signed(value));
      REG_ORIGIN_IM: view_origin_im = longint'($signed(value));
      REG_STEP_RE:   view_step_re   = longint'(value[UWORD_BITS-1:0]);
      REG_STEP_IM:   view_step_im   = longint'(value[UWORD_BITS-1:0]);
      REG_ITER_LIM:  view_limit     = 32'(value[COUNT_BITS-1:0]);
      REG_RADIUS_SQ: view_radius_sq = longint'(value[UWORD_BITS-1:0]);
      default: ;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Driver: offer queued coordinates, predict each accepted transfer
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        pixel_expected.push_back(escape_pixel(in_data));
      end
      // Hold the payload while a transfer is pending; otherwise load the next
      // coordinate or go idle.
      if (!in_valid || in_ready) begin
        if (pixel_backlog.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= pixel_backlog.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: compare each result transfer with the oldest prediction
  // --------------------------------------------------------------------------
  task automatic note_fault(input string what, input pixel_out_t want, input pixel_out_t got);
    if (mismatches < MAX_REPORTS) begin
      $display("%0t %s: exp col %0d row %0d n %0d in %0b rgb %0d/%0d/%0d",
               $realtime, what, want.out_col, want.out_row, want.iteration_count,
               want.inside_res, want.red, want.green, want.blue);
      $display("%0t %s: got col %0d row %0d n %0d in %0b rgb %0d/%0d/%0d",
               $realtime, what, got.out_col, got.out_row, got.iteration_count,
               got.inside_res, got.red, got.green, got.blue);
    end
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pixel_expected.size() == 0) begin
          note_fault("unexpected pixel", '0, out_data);
        end else begin
          want_pixel = pixel_expected.pop_front();
          if (out_data.out_col != want_pixel.out_col ||
              out_data.out_row != want_pixel.out_row ||
              out_data.iteration_count != want_pixel.iteration_count ||
              out_data.inside_res != want_pixel.inside_res ||
              out_data.red != want_pixel.red ||
              out_data.green != want_pixel.green ||
              out_data.blue != want_pixel.blue) begin
            note_fault("pixel mismatch", want_pixel, out_data);
          end
        end
      end
      out_ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: abort when no channel moves a transfer for too long. The limit
  // covers a full-limit pixel several times over.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus sequencing
  // --------------------------------------------------------------------------

  // Write one register through the config channel and mirror it
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [WORD_BITS-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, value);
    cfg_valid <= 1'b0;
  endtask

  // Block until every queued coordinate is in and every pixel is back
  task automatic wait_drained();
    do @(negedge clk);
    while (pixel_backlog.size() != 0 || in_valid || pixel_expected.size() != 0);
  endtask

  // Drain, load a full view setup, then set the idling mix for the phase
  task automatic load_view(input word_t o_re, input word_t o_im,
                           input uword_t s_re, input uword_t s_im,
                           input count_t lim, input uword_t rad,
                           input int src_pct, input int snk_pct);
    wait_drained();
    write_reg(REG_ORIGIN_RE, o_re);
    write_reg(REG_ORIGIN_IM, o_im);
    write_reg(REG_STEP_RE, 32'(s_re));
    write_reg(REG_STEP_IM, 32'(s_im));
    write_reg(REG_ITER_LIM, 32'(lim));
    write_reg(REG_RADIUS_SQ, 32'(rad));
    @(negedge clk);
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
  endtask

  task automatic queue_pixel(input pix_t col, input pix_t row);
    pixel_in_t px;
    px.pixel_col = col;
    px.pixel_row = row;
    pixel_backlog.push_back(px);
  endtask

  initial begin : stimulus
    word_t  o_re, o_im;
    uword_t s_re, s_im, rad;
    count_t lim;
    int     p;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset view: corners, a point deep in the main cardioid, a few others
    queue_pixel(11'd0, 11'd0);
    queue_pixel(11'd2047, 11'd2047);
    queue_pixel(11'd0, 11'd2047);
    queue_pixel(11'd2047, 11'd0);
    queue_pixel(11'd512, 11'd256);
    queue_pixel(11'd1023, 11'd1024);
    queue_pixel(11'd1365, 11'd682);
    queue_pixel(11'd341, 11'd1706);

    // Zero limit: c = 0 everywhere, one update still runs, reports inside
    load_view('0, '0, '0, '0, '0, Q_FOUR, 0, 0);
    queue_pixel(11'd5, 11'd7);
    queue_pixel(11'd2047, 11'd0);

    // Escape on the last allowed iteration: c at or beyond 3, limit 1
    load_view(Q_THREE, '0, 31'd1048576, 31'd1048576, 16'd1, Q_FOUR, 0, 0);
    queue_pixel(11'd0, 11'd0);
    queue_pixel(11'd100, 11'd3);
    queue_pixel(11'd2047, 11'd2047);

    // Zero radius: every pixel escapes after one update, far from the limit
    load_view(Q_MINUS_TWO, Q_MINUS_ONE, DEF_STEP_RE, DEF_STEP_IM, LIMIT_MAX, '0, 0, 0);
    queue_pixel(11'd512, 11'd256);
    queue_pixel(11'd1024, 11'd1024);
    queue_pixel(11'd2047, 11'd0);

    // Coordinate overflow and saturated magnitude against the largest radius
    load_view(SWORD_MIN, SWORD_MAX, UWORD_MAX, UWORD_MAX, LIMIT_MAX, UWORD_MAX, 0, 0);
    queue_pixel(11'd0, 11'd0);
    queue_pixel(11'd1, 11'd0);
    queue_pixel(11'd2047, 11'd2047);
    queue_pixel(11'd0, 11'd2047);

    // Random views: idling mix rotates through none, source, sink, both
    for (p = 0; p < RANDOM_VIEWS; p++) begin
      o_re = word_t'(-671088640 + int'($urandom_range(0, 402653184)));
      o_im = word_t'(-402653184 + int'($urandom_range(0, 268435456)));
      s_re = uword_t'($urandom_range(1 << 16, 1 << 20));
      s_im = uword_t'($urandom_range(1 << 16, 1 << 20));
      lim  = count_t'($urandom_range(2, 300));
      rad  = ($urandom_range(0, 3) == 0) ? uword_t'($urandom()) : Q_FOUR;
      case (p)
        0: begin
          // Write the reset view back explicitly
          o_re = Q_MINUS_TWO;
          o_im = Q_MINUS_ONE;
          s_re = DEF_STEP_RE;
          s_im = DEF_STEP_IM;
          lim  = DEF_LIMIT;
          rad  = Q_FOUR;
        end
        3: begin
          // Saturating extremes: every pixel escapes at once despite max limit
          o_re = SWORD_MIN;
          o_im = SWORD_MAX;
          s_re = UWORD_MAX;
          s_im = UWORD_MAX;
          lim  = LIMIT_MAX;
          rad  = UWORD_MAX;
        end
        5: begin
          // Tiny limits hit the inside/last-iteration path often
          lim = count_t'($urandom_range(1, 8));
          rad = uword_t'($urandom());
        end
        default: ;
      endcase
      load_view(o_re, o_im, s_re, s_im, lim, rad,
                (p % 4 == 1) ? 64 : ((p % 4 == 3) ? 12 : 0),
                (p % 4 == 2) ? 64 : ((p % 4 == 3) ? 12 : 0));
      repeat (VIEW_PIXELS) begin
        queue_pixel(pix_t'($urandom_range(0, 2047)), pix_t'($urandom_range(0, 2047)));
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (pixel_expected.size() != 0) begin
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> mandelbrot_pixel_iterator_unit.f
rtl/mpi_pkg.sv
rtl/mpi_front.sv
rtl/mpi_queue.sv
rtl/mpi_core.sv
rtl/mandelbrot_pixel_iterator_unit.sv
tb/mandelbrot_pixel_iterator_unit_tb.sv
